@@ design/bsb_pkg.sv @@
// Shared types and constants for the batch sorter.
package bsb_pkg;

  localparam int VALUE_W = 32;
  localparam int MAX_ITEMS_DEFAULT = 32;
  localparam int QUEUE_DEPTH = 2;

  typedef logic signed [VALUE_W-1:0] value_t;

  typedef struct packed {
    value_t value;
    logic   last;
    logic   drop;
  } bsb_cmd_t;

  typedef enum logic [2:0] {
    ST_LOAD,
    ST_SORT_INIT,
    ST_SORT_LOAD,
    ST_SORT_RUN,
    ST_SORT_FLUSH,
    ST_EMIT_RD,
    ST_EMIT_WR
  } bsb_state_t;

endpackage

@@ design/bsb_if.sv @@
// Valid/ready channel interfaces for the input and result items.
interface bsb_in_if import bsb_pkg::*; ();
  logic   valid;
  logic   ready;
  value_t value;
  logic   last_in;

  modport source (output valid, output value, output last_in, input ready);
  modport sink (input valid, input value, input last_in, output ready);
endinterface

interface bsb_out_if import bsb_pkg::*; ();
  logic   valid;
  logic   ready;
  value_t sorted_value;
  logic   last_out;
  logic   overflow;

  modport source (output valid, output sorted_value, output last_out, output overflow,
                  input ready);
  modport sink (input valid, input sorted_value, input last_out, input overflow,
                output ready);
endinterface

@@ design/bsb_front.sv @@
// Input stage that accepts items and marks those that no longer fit the store.
module bsb_front import bsb_pkg::*; #(
  parameter int MAX_ITEMS = MAX_ITEMS_DEFAULT
) (
  input  logic     clk,
  input  logic     rst_n,
  bsb_in_if.sink   in_if,
  output bsb_cmd_t push_cmd,
  output logic     push_valid,
  input  logic     push_ready
);

  localparam int CNT_W = $clog2(MAX_ITEMS + 1);

  logic [CNT_W-1:0] cnt_r;
  logic [CNT_W-1:0] cnt_nxt;
  logic             full;
  logic             accept;

  assign full           = (cnt_r == CNT_W'(MAX_ITEMS));
  assign accept         = in_if.valid && push_ready;
  assign in_if.ready    = push_ready;
  assign push_valid     = in_if.valid;
  assign push_cmd.value = in_if.value;
  assign push_cmd.last  = in_if.last_in;
  assign push_cmd.drop  = full;

  always_comb begin
    cnt_nxt = cnt_r;
    if (accept) begin
      if (in_if.last_in) begin
        cnt_nxt = '0;
      end else if (!full) begin
        cnt_nxt = cnt_r + CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else begin
      cnt_r <= cnt_nxt;
    end
  end

endmodule

@@ design/bsb_fifo.sv @@
// Short command queue between the input stage and the sort engine.
module bsb_fifo import bsb_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  bsb_cmd_t push_cmd,
  input  logic     push_valid,
  output logic     push_ready,
  output bsb_cmd_t pop_cmd,
  output logic     pop_valid,
  input  logic     pop_ready
);

  localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  bsb_cmd_t         entries_r [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr_r;
  logic [PTR_W-1:0] rd_ptr_r;
  logic [CNT_W-1:0] count_r;
  logic             push;
  logic             pop;

  assign push_ready = (count_r != CNT_W'(QUEUE_DEPTH));
  assign pop_valid  = (count_r != '0);
  assign pop_cmd    = entries_r[rd_ptr_r];
  assign push       = push_valid && push_ready;
  assign pop        = pop_valid && pop_ready;

  always_ff @(posedge clk) begin
    if (push) begin
      entries_r[wr_ptr_r] <= push_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= (wr_ptr_r == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_r + PTR_W'(1);
      end
      if (pop) begin
        rd_ptr_r <= (rd_ptr_r == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_r + PTR_W'(1);
      end
      case ({push, pop})
        2'b10:   count_r <= count_r + CNT_W'(1);
        2'b01:   count_r <= count_r - CNT_W'(1);
        default: count_r <= count_r;
      endcase
    end
  end

endmodule

@@ design/bsb_back.sv @@
// Sort engine: stores a batch, sorts it with bubble passes and emits it in order.
module bsb_back import bsb_pkg::*; #(
  parameter int MAX_ITEMS = MAX_ITEMS_DEFAULT
) (
  input  logic     clk,
  input  logic     rst_n,
  input  bsb_cmd_t pop_cmd,
  input  logic     pop_valid,
  output logic     pop_ready,
  bsb_out_if.source out_if
);

  localparam int CNT_W  = $clog2(MAX_ITEMS + 1);
  localparam int ADDR_W = $clog2(MAX_ITEMS);

  value_t           mem [MAX_ITEMS];
  value_t           rdata_r;
  logic [ADDR_W-1:0] rd_addr;
  logic [ADDR_W-1:0] wr_addr;
  value_t           wr_data;
  logic             we;

  bsb_state_t       state_r;
  bsb_state_t       state_nxt;
  logic [CNT_W-1:0] cnt_r;
  logic [CNT_W-1:0] cnt_nxt;
  logic             dropped_r;
  logic             dropped_nxt;
  logic [CNT_W-1:0] idx_r;
  logic [CNT_W-1:0] idx_nxt;
  value_t           carry_r;
  value_t           carry_nxt;
  logic             swapped_r;
  logic             swapped_nxt;

  logic             out_valid_r;
  logic             out_valid_nxt;
  value_t           out_value_r;
  logic             out_last_r;
  logic             out_ovf_r;
  logic             load_out;
  logic             emit_last;

  logic [CNT_W-1:0] cnt_inc;
  logic [CNT_W-1:0] cnt_m1;
  logic [CNT_W-1:0] idx_m2;
  logic             swap;

  assign cnt_inc   = cnt_r + CNT_W'(1);
  assign cnt_m1    = cnt_r - CNT_W'(1);
  assign idx_m2    = idx_r - CNT_W'(2);
  assign swap      = (carry_r > rdata_r);
  assign emit_last = (idx_r == cnt_m1);

  always_comb begin
    state_nxt     = state_r;
    cnt_nxt       = cnt_r;
    dropped_nxt   = dropped_r;
    idx_nxt       = idx_r;
    carry_nxt     = carry_r;
    swapped_nxt   = swapped_r;
    we            = 1'b0;
    wr_addr       = '0;
    wr_data       = pop_cmd.value;
    rd_addr       = '0;
    pop_ready     = 1'b0;
    load_out      = 1'b0;
    out_valid_nxt = out_valid_r && !out_if.ready;
    case (state_r)
      ST_LOAD: begin
        pop_ready = 1'b1;
        if (pop_valid) begin
          if (!pop_cmd.drop) begin
            we      = 1'b1;
            wr_addr = cnt_r[ADDR_W-1:0];
            cnt_nxt = cnt_inc;
          end else begin
            dropped_nxt = 1'b1;
          end
          if (pop_cmd.last) begin
            idx_nxt = '0;
            if (!pop_cmd.drop && cnt_r == '0) begin
              state_nxt = ST_EMIT_RD;
            end else begin
              state_nxt = ST_SORT_INIT;
            end
          end
        end
      end
      ST_SORT_INIT: begin
        rd_addr     = '0;
        idx_nxt     = CNT_W'(1);
        swapped_nxt = 1'b0;
        state_nxt   = ST_SORT_LOAD;
      end
      ST_SORT_LOAD: begin
        carry_nxt = rdata_r;
        rd_addr   = idx_r[ADDR_W-1:0];
        idx_nxt   = idx_r + CNT_W'(1);
        state_nxt = ST_SORT_RUN;
      end
      ST_SORT_RUN: begin
        we        = 1'b1;
        wr_addr   = idx_m2[ADDR_W-1:0];
        wr_data   = swap ? rdata_r : carry_r;
        carry_nxt = swap ? carry_r : rdata_r;
        if (swap) begin
          swapped_nxt = 1'b1;
        end
        if (idx_r == cnt_r) begin
          state_nxt = ST_SORT_FLUSH;
        end else begin
          rd_addr = idx_r[ADDR_W-1:0];
          idx_nxt = idx_r + CNT_W'(1);
        end
      end
      ST_SORT_FLUSH: begin
        we      = 1'b1;
        wr_addr = cnt_m1[ADDR_W-1:0];
        wr_data = carry_r;
        if (swapped_r) begin
          state_nxt = ST_SORT_INIT;
        end else begin
          idx_nxt   = '0;
          state_nxt = ST_EMIT_RD;
        end
      end
      ST_EMIT_RD: begin
        rd_addr   = idx_r[ADDR_W-1:0];
        state_nxt = ST_EMIT_WR;
      end
      ST_EMIT_WR: begin
        rd_addr = idx_r[ADDR_W-1:0];
        if (!out_valid_r || out_if.ready) begin
          load_out      = 1'b1;
          out_valid_nxt = 1'b1;
          if (emit_last) begin
            cnt_nxt     = '0;
            dropped_nxt = 1'b0;
            state_nxt   = ST_LOAD;
          end else begin
            idx_nxt   = idx_r + CNT_W'(1);
            state_nxt = ST_EMIT_RD;
          end
        end
      end
      default: begin
        state_nxt = ST_LOAD;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (we) begin
      mem[wr_addr] <= wr_data;
    end
    rdata_r <= mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_LOAD;
      cnt_r       <= '0;
      dropped_r   <= 1'b0;
      idx_r       <= '0;
      swapped_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      dropped_r   <= dropped_nxt;
      idx_r       <= idx_nxt;
      swapped_r   <= swapped_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    carry_r <= carry_nxt;
    if (load_out) begin
      out_value_r <= rdata_r;
      out_last_r  <= emit_last;
      out_ovf_r   <= dropped_r;
    end
  end

  assign out_if.valid        = out_valid_r;
  assign out_if.sorted_value = out_value_r;
  assign out_if.last_out     = out_last_r;
  assign out_if.overflow     = out_ovf_r;

`ifndef SYNTHESIS
  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CNT_W'(MAX_ITEMS))
    else $error("stored count exceeds capacity");

  a_sort_min: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_SORT_INIT) |-> (cnt_r >= CNT_W'(2)))
    else $error("sort pass started on fewer than two values");

  a_emit_order: assert property (@(posedge clk) disable iff (!rst_n)
    (load_out && idx_r != '0) |-> (rdata_r >= out_value_r))
    else $error("emitted values are not ascending");

  a_batch_clear: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_EMIT_WR && load_out && emit_last) |=>
      (state_r == ST_LOAD && cnt_r == '0 && !dropped_r))
    else $error("batch state not cleared after final result");
`endif

endmodule

@@ design/bubble_sort_batch_core.sv @@
// Batch sorter: collects signed values until the item marked last, then emits them in
// ascending order with equal values kept in arrival order. Loading takes one item per
// cycle while the engine is idle; a two-entry queue lets the input run ahead while the
// engine sorts or emits. After the closing item of a batch of two or more values, the
// engine runs bubble passes over a store with one read and one write port; passes repeat
// until one makes no swap (at most n passes for n stored values). Each result is read
// from the store into the output register, which holds while the output is stalled.
// Values beyond MAX_ITEMS are dropped and every result of that batch carries overflow.
module bubble_sort_batch_core import bsb_pkg::*; #(
  parameter int MAX_ITEMS = MAX_ITEMS_DEFAULT
) (
  input  logic      clk,
  input  logic      rst_n,
  bsb_in_if.sink    in_if,
  bsb_out_if.source out_if
);

  bsb_cmd_t push_cmd;
  logic     push_valid;
  logic     push_ready;
  bsb_cmd_t pop_cmd;
  logic     pop_valid;
  logic     pop_ready;

  bsb_front #(.MAX_ITEMS(MAX_ITEMS)) u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_if      (in_if),
    .push_cmd   (push_cmd),
    .push_valid (push_valid),
    .push_ready (push_ready)
  );

  bsb_fifo u_fifo (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_cmd   (push_cmd),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .pop_cmd    (pop_cmd),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready)
  );

  bsb_back #(.MAX_ITEMS(MAX_ITEMS)) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .pop_cmd   (pop_cmd),
    .pop_valid (pop_valid),
    .pop_ready (pop_ready),
    .out_if    (out_if)
  );

endmodule

@@ sim/bubble_sort_batch_core_tb.sv @@
// Testbench for bubble_sort_batch_core: random batches checked against a stable ascending sort.
`timescale 1ns / 100ps

typedef struct {
  bsb_pkg::value_t val;
  logic            last;
  logic            ovf;
} sorted_item_t;

class sort_scoreboard;
  bsb_pkg::value_t batch_vals[$];
  bit              batch_dropped;
  sorted_item_t    sorted_q[$];
  int unsigned     mismatches;

  function void note_input(bsb_pkg::value_t v, logic last);
    bsb_pkg::value_t ordered[$];
    sorted_item_t    exp_item;
    int              pos;
    if (batch_vals.size() < bsb_pkg::MAX_ITEMS_DEFAULT) begin
      batch_vals.push_back(v);
    end else begin
      batch_dropped = 1'b1;
    end
    if (last) begin
      // An insertion after every smaller or equal value keeps equal values in arrival order.
      foreach (batch_vals[i]) begin
        pos = ordered.size();
        for (int k = 0; k < ordered.size(); k++) begin
          if (ordered[k] > batch_vals[i]) begin
            pos = k;
            break;
          end
        end
        ordered.insert(pos, batch_vals[i]);
      end
      foreach (ordered[i]) begin
        exp_item.val  = ordered[i];
        exp_item.last = (i == ordered.size() - 1);
        exp_item.ovf  = batch_dropped;
        sorted_q.push_back(exp_item);
      end
      batch_vals.delete();
      batch_dropped = 1'b0;
    end
  endfunction

  function void check_result(bsb_pkg::value_t v, logic last, logic ovf);
    sorted_item_t exp_item;
    if (sorted_q.size() == 0) begin
      if (mismatches < 10) begin
        $display("unexpected item: value %0d last %b overflow %b", v, last, ovf);
      end
      mismatches++;
    end else begin
      exp_item = sorted_q.pop_front();
      if (v !== exp_item.val || last !== exp_item.last || ovf !== exp_item.ovf) begin
        if (mismatches < 10) begin
          $display("mismatch: expected value %0d last %b overflow %b, got %0d %b %b",
                   exp_item.val, exp_item.last, exp_item.ovf, v, last, ovf);
        end
        mismatches++;
      end
    end
  endfunction

  function int unsigned pending();
    return sorted_q.size();
  endfunction
endclass

module bubble_sort_batch_core_tb;
  import bsb_pkg::*;

  localparam int CAPACITY = MAX_ITEMS_DEFAULT;
  localparam int TARGET_ITEMS = 320;
  localparam int CYCLE_LIMIT = 1000000;

  typedef enum int {VM_WIDE, VM_DUPS, VM_EXTREME, VM_SHORT} value_mode_t;

  logic        clk;
  logic        rst_n;
  logic        calm;
  int          stall_left;
  int          out_gap;
  int unsigned cycles;
  int          items_sent;

  sort_scoreboard sorted_sb;

  bsb_in_if  in_ch ();
  bsb_out_if out_ch ();

  bubble_sort_batch_core #(.MAX_ITEMS(CAPACITY)) dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_if  (in_ch),
    .out_if (out_ch)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (calm || r < 65) return 0;
    if (r < 93) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic value_t rand_value(value_mode_t mode);
    value_t v;
    case (mode)
      VM_DUPS: begin
        v = value_t'($urandom_range(0, 6)) - 3;
      end
      VM_EXTREME: begin
        case ($urandom_range(0, 4))
          0: v = 32'sh8000_0000;
          1: v = 32'sh7fff_ffff;
          2: v = 32'sh0000_0000;
          3: v = -32'sd1;
          default: v = 32'sd1;
        endcase
      end
      VM_SHORT: begin
        v = value_t'($urandom >> $urandom_range(0, 31));
        if ($urandom_range(0, 1) == 1) v = -v;
      end
      default: begin
        v = value_t'($urandom);
      end
    endcase
    return v;
  endfunction

  task automatic send_value(value_t v, logic last);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid   <= 1'b1;
    in_ch.value   <= v;
    in_ch.last_in <= last;
    do @(posedge clk); while (!in_ch.ready);
    sorted_sb.note_input(v, last);
    items_sent++;
  endtask

  task automatic send_batch(int n, value_mode_t mode);
    for (int i = 0; i < n; i++) begin
      send_value(rand_value(mode), i == n - 1);
    end
  endtask

  task automatic send_list(value_t vals[$]);
    foreach (vals[i]) begin
      send_value(vals[i], i == vals.size() - 1);
    end
  endtask

  function automatic int pick_batch_size();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return $urandom_range(1, 6);
    if (r < 78) return $urandom_range(7, 16);
    if (r < 90) return $urandom_range(17, CAPACITY);
    return $urandom_range(CAPACITY + 1, CAPACITY + 8);
  endfunction

  always @(posedge clk) begin
    if (stall_left != 0) begin
      out_ch.ready <= 1'b0;
      stall_left   <= stall_left - 1;
    end else begin
      out_gap = pick_gap();
      if (out_gap == 0) begin
        out_ch.ready <= 1'b1;
      end else begin
        out_ch.ready <= 1'b0;
        stall_left   <= out_gap - 1;
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_ch.valid && out_ch.ready) begin
      sorted_sb.check_result(out_ch.sorted_value, out_ch.last_out, out_ch.overflow);
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("bubble_sort_batch_core_tb NOT OK");
      $finish;
    end
  end

  initial begin
    sorted_sb     = new();
    rst_n         = 1'b0;
    calm          = 1'b0;
    stall_left    = 0;
    out_gap       = 0;
    cycles        = 0;
    items_sent    = 0;
    in_ch.valid   = 1'b0;
    in_ch.value   = '0;
    in_ch.last_in = 1'b0;
    out_ch.ready  = 1'b0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    send_list('{32'sh7fff_ffff});
    send_list('{32'sh8000_0000, 32'sh7fff_ffff, 32'sd0, -32'sd1, 32'sd1});
    send_list('{32'sd5, -32'sd3, 32'sd5, -32'sd3, 32'sd5});
    send_list('{-32'sd2, -32'sd1, 32'sd0, 32'sd1});
    send_list('{32'sd3, 32'sd2, 32'sd1, 32'sd0, -32'sd1});

    send_batch(CAPACITY, VM_WIDE);
    send_batch(CAPACITY + 1, VM_DUPS);
    send_batch(2, VM_EXTREME);
    send_batch(CAPACITY + 8, VM_SHORT);
    while (items_sent < TARGET_ITEMS) begin
      calm <= ($urandom_range(0, 4) == 0);
      send_batch(pick_batch_size(), value_mode_t'($urandom_range(0, 3)));
    end
    in_ch.valid <= 1'b0;
    calm        <= 1'b0;

    while (sorted_sb.pending() != 0) @(posedge clk);
    repeat (100) @(posedge clk);

    if (sorted_sb.mismatches == 0 && sorted_sb.pending() == 0) begin
      $display("bubble_sort_batch_core_tb OK");
    end else begin
      $display("bubble_sort_batch_core_tb NOT OK");
    end
    $finish;
  end
endmodule
